// ===== rtl/modbus_rtu_slave_engine_unit_defines.svh =====
// Assertion macros for the Modbus RTU slave engine.
// The design clock is clk and the design reset is rst_n.
`ifndef MODBUS_RTU_SLAVE_ENGINE_UNIT_DEFINES_SVH
`define MODBUS_RTU_SLAVE_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define MRTU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrtu assertion failed");
// Next-cycle implication.
`define MRTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrtu assertion failed");
`else
`define MRTU_ASSERT_IMPL(label, ante, cons)
`define MRTU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/mrtu_pkg.sv =====
`default_nettype none

package mrtu_pkg;

    localparam logic [7:0] ADDR_RESET  = 8'h01;
    localparam logic [7:0] FC_READ     = 8'h03;
    localparam logic [7:0] FC_WRITE    = 8'h10;
    localparam logic [7:0] EXC_FLAG    = 8'h80;
    localparam logic [7:0] EXC_BAD_REQ = 8'h00;
    localparam logic [7:0] EXC_BAD_CRC = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int LEN_W = 9;   // frame length counter
    localparam int QW    = 5;   // quantity counter (quantity up to 29)
    localparam int TXW   = 6;   // response byte index (up to 63 bytes)

    typedef enum logic [1:0] {
        MODE_SERIAL = 2'd0,
        MODE_LWRITE = 2'd1,
        MODE_LREAD  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RK_EXC,
        RK_READ,
        RK_WRITE
    } resp_kind_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LREAD,
        S_LOUT,
        S_RX_CRC,
        S_WR_HI,
        S_WR_LO,
        S_WR_WR,
        S_TX_SEL,
        S_TX_RD,
        S_TX_LD,
        S_TX_OUT
    } state_t;

    typedef struct packed {
        logic       init;
        logic       load;
        logic [7:0] data;
    } crc_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mrtu_ram.sv =====
`default_nettype none

module mrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/mrtu_crc.sv =====
`default_nettype none

// Bit-serial CRC-16/MODBUS: one data bit per cycle.
module mrtu_crc
    import mrtu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire crc_ctl_t ctl,
    output logic [15:0]   crc,
    output logic          busy
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  dat_reg, dat_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        fb;

    always_comb
    begin
        crc_next = crc_reg;
        dat_next = dat_reg;
        cnt_next = cnt_reg;
        fb       = crc_reg[0] ^ dat_reg[0];
        if (ctl.load)
        begin
            crc_next = ctl.init ? CRC_INIT : crc_reg;
            dat_next = ctl.data;
            cnt_next = 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_next = {1'b0, crc_reg[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
            dat_next = {1'b0, dat_reg[7:1]};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 4'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        dat_reg <= dat_next;
    end

    assign crc  = crc_reg;
    assign busy = (cnt_reg != 4'd0);

endmodule

`default_nettype wire

// ===== rtl/modbus_rtu_slave_engine_unit.sv =====
`default_nettype none

// Channel  | Signals                                           | Beat when
// ---------+---------------------------------------------------+-------------------------
// input    | in_valid, in_stall, mode, rx_byte, local_index,   | in_valid && !in_stall
//          | local_value                                       |
// output   | out_valid, out_stall, kind, tx_byte, tx_last,     | out_valid && !out_stall
//          | read_value                                        |
// config   | cfg_valid, cfg_ready, slave_address               | cfg_valid && cfg_ready
//
// After reset the register memory is cleared, one word a cycle, with in_stall high.
// Config writes are taken at any time.
// A serial byte goes to the frame buffer and the bit-serial CRC; then S_RX_CRC waits
// for the CRC. Local writes are taken in idle; a local read reads (S_LREAD) and hands
// off (S_LOUT) the word. Response bytes, up to 63, are selected, loaded and handed off;
// a read word's high byte is first fetched, and a write request first copies each word
// from the frame buffer into the memory. A stalled output holds the engine in the
// handoff step; one finished beat may wait while a new item is accepted.
`include "modbus_rtu_slave_engine_unit_defines.svh"

module modbus_rtu_slave_engine_unit
    import mrtu_pkg::*;
#(
    parameter int MEM_WORDS    = 1024,
    parameter int MAX_QUANTITY = 29,
    parameter int FRAME_BYTES  = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [9:0]  local_index,
    input  wire logic [15:0] local_value,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [7:0]       tx_byte,
    output logic             tx_last,
    output logic [15:0]      read_value,
    // config channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  slave_address
);

    localparam int AW  = $clog2(MEM_WORDS);
    localparam int FAW = $clog2(FRAME_BYTES);
    localparam logic [LEN_W-1:0] FB        = LEN_W'(FRAME_BYTES);
    localparam logic [16:0]      MEM_LIM   = 17'(MEM_WORDS);
    localparam logic [15:0]      QTY_LIM   = 16'(MAX_QUANTITY);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(MEM_WORDS - 1);

    // control state
    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [7:0]         addr_reg;
    logic               out_valid_reg;

    // working registers
    logic [7:0]         fc_reg, fc_next;
    logic [15:0]        st_reg, st_next;
    logic [15:0]        qt_reg, qt_next;
    logic [7:0]         bc_reg, bc_next;
    logic [7:0]         code_reg, code_next;
    resp_kind_t         rk_reg, rk_next;
    logic [TXW-1:0]     j_reg, j_next;
    logic [7:0]         tb_reg, tb_next;
    logic [15:0]        word_reg, word_next;
    logic [AW-1:0]      wa_reg, wa_next;
    logic [FAW-1:0]     fp_reg, fp_next;
    logic [QW-1:0]      wc_reg, wc_next;
    logic [7:0]         hb_reg, hb_next;
    logic               lr_ok_reg, lr_ok_next;

    // output payload
    logic               kind_reg;
    logic [7:0]         tx_byte_reg;
    logic               tx_last_reg;
    logic [15:0]        read_value_reg;
    logic               out_load;
    logic               o_kind;
    logic [7:0]         o_byte;
    logic               o_last;
    logic [15:0]        o_val;

    // memories
    logic               hram_we;
    logic [AW-1:0]      hram_waddr, hram_raddr;
    logic [15:0]        hram_wdata, hram_rdata;
    logic               fram_we;
    logic [FAW-1:0]     fram_waddr, fram_raddr;
    logic [7:0]         fram_wdata, fram_rdata;

    // CRC unit
    crc_ctl_t           crc_ctl;
    logic [15:0]        crc_val;
    logic               crc_busy;

    // request checks
    logic               idx_ok;
    logic               req_bad;
    logic [LEN_W-1:0]   need;
    logic [TXW-1:0]     body_n;
    logic [TXW-1:0]     rd_off;
    logic [QW-1:0]      wc_inc;

    mrtu_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_hold (
        .clk   (clk),
        .we    (hram_we),
        .waddr (hram_waddr),
        .wdata (hram_wdata),
        .raddr (hram_raddr),
        .rdata (hram_rdata)
    );

    mrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
        .clk   (clk),
        .we    (fram_we),
        .waddr (fram_waddr),
        .wdata (fram_wdata),
        .raddr (fram_raddr),
        .rdata (fram_rdata)
    );

    mrtu_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .crc   (crc_val),
        .busy  (crc_busy)
    );

    assign idx_ok  = ({7'd0, local_index} < MEM_LIM);
    assign need    = LEN_W'(9) + {1'b0, bc_reg};
    assign req_bad = (qt_reg == 16'd0) || (qt_reg > QTY_LIM)
                     || (({1'b0, st_reg} + {1'b0, qt_reg}) > MEM_LIM)
                     || ((fc_reg == FC_WRITE) && ({8'd0, bc_reg} != {qt_reg[14:0], 1'b0}));
    assign rd_off  = j_reg - TXW'(3);
    assign wc_inc  = wc_reg + QW'(1);

    // payload bytes before the CRC
    always_comb
    begin
        case (rk_reg)
            RK_READ:  body_n = TXW'(3) + {qt_reg[TXW-2:0], 1'b0};
            RK_WRITE: body_n = TXW'(6);
            default:  body_n = TXW'(3);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        clr_next   = clr_reg;
        fc_next    = fc_reg;
        st_next    = st_reg;
        qt_next    = qt_reg;
        bc_next    = bc_reg;
        code_next  = code_reg;
        rk_next    = rk_reg;
        j_next     = j_reg;
        tb_next    = tb_reg;
        word_next  = word_reg;
        wa_next    = wa_reg;
        fp_next    = fp_reg;
        wc_next    = wc_reg;
        hb_next    = hb_reg;
        lr_ok_next = lr_ok_reg;

        hram_we    = 1'b0;
        hram_waddr = wa_reg;
        hram_wdata = 16'd0;
        hram_raddr = wa_reg;
        fram_we    = 1'b0;
        fram_waddr = len_reg[FAW-1:0];
        fram_wdata = rx_byte;
        fram_raddr = fp_reg;
        crc_ctl    = '0;

        out_load   = 1'b0;
        o_kind     = 1'b0;
        o_byte     = 8'd0;
        o_last     = 1'b0;
        o_val      = 16'd0;

        case (state_reg)
            S_CLEAR:
            begin
                hram_we    = 1'b1;
                hram_waddr = clr_reg;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                hram_raddr = AW'(local_index);
                if (in_valid)
                begin
                    case (mode)
                        MODE_SERIAL:
                        begin
                            if ((len_reg != '0) || (rx_byte == addr_reg))
                            begin
                                if (len_reg >= FB)
                                begin
                                    len_next = '0;
                                end
                                else
                                begin
                                    fram_we      = 1'b1;
                                    crc_ctl.init = (len_reg == '0);
                                    crc_ctl.load = 1'b1;
                                    crc_ctl.data = rx_byte;
                                    case (len_reg)
                                        LEN_W'(1): fc_next       = rx_byte;
                                        LEN_W'(2): st_next[15:8] = rx_byte;
                                        LEN_W'(3): st_next[7:0]  = rx_byte;
                                        LEN_W'(4): qt_next[15:8] = rx_byte;
                                        LEN_W'(5): qt_next[7:0]  = rx_byte;
                                        LEN_W'(6): bc_next       = rx_byte;
                                        default: ;
                                    endcase
                                    len_next   = len_reg + LEN_W'(1);
                                    state_next = S_RX_CRC;
                                end
                            end
                        end
                        MODE_LWRITE:
                        begin
                            if (idx_ok)
                            begin
                                hram_we    = 1'b1;
                                hram_waddr = AW'(local_index);
                                hram_wdata = local_value;
                            end
                        end
                        MODE_LREAD:
                        begin
                            lr_ok_next = idx_ok;
                            state_next = S_LREAD;
                        end
                        default: ;
                    endcase
                end
            end

            S_LREAD:
            begin
                word_next  = lr_ok_reg ? hram_rdata : 16'd0;
                state_next = S_LOUT;
            end

            S_LOUT:
            begin
                if (!out_valid_reg)
                begin
                    out_load   = 1'b1;
                    o_kind     = 1'b1;
                    o_val      = word_reg;
                    state_next = S_IDLE;
                end
            end

            S_RX_CRC:
            begin
                if (!crc_busy)
                begin
                    state_next = S_IDLE;
                    if (len_reg >= LEN_W'(2))
                    begin
                        if (fc_reg == FC_READ || fc_reg == FC_WRITE)
                        begin
                            if (fc_reg == FC_WRITE && len_reg >= LEN_W'(7) && need > FB)
                            begin
                                len_next = '0;
                            end
                            else if ((fc_reg == FC_READ && len_reg == LEN_W'(8))
                                     || (fc_reg == FC_WRITE && len_reg >= LEN_W'(7)
                                         && len_reg == need))
                            begin
                                // frame complete
                                len_next  = '0;
                                j_next    = '0;
                                wa_next   = AW'(st_reg);
                                fp_next   = FAW'(7);
                                wc_next   = '0;
                                code_next = req_bad ? EXC_BAD_REQ : EXC_BAD_CRC;
                                if (req_bad || crc_val != 16'd0)
                                begin
                                    rk_next    = RK_EXC;
                                    state_next = S_TX_SEL;
                                end
                                else if (fc_reg == FC_READ)
                                begin
                                    rk_next    = RK_READ;
                                    state_next = S_TX_SEL;
                                end
                                else
                                begin
                                    rk_next    = RK_WRITE;
                                    state_next = S_WR_HI;
                                end
                            end
                        end
                        else
                        begin
                            // unknown function: drop
                            len_next = '0;
                        end
                    end
                end
            end

            S_WR_HI:
            begin
                fp_next    = fp_reg + FAW'(1);
                state_next = S_WR_LO;
            end

            S_WR_LO:
            begin
                hb_next    = fram_rdata;
                fp_next    = fp_reg + FAW'(1);
                state_next = S_WR_WR;
            end

            S_WR_WR:
            begin
                hram_we    = 1'b1;
                hram_wdata = {hb_reg, fram_rdata};
                wa_next    = wa_reg + AW'(1);
                wc_next    = wc_inc;
                state_next = (wc_inc == qt_reg[QW-1:0]) ? S_TX_SEL : S_WR_HI;
            end

            S_TX_SEL:
            begin
                state_next = S_TX_LD;
                if (j_reg == body_n)
                begin
                    tb_next = crc_val[7:0];
                end
                else if (j_reg == body_n + TXW'(1))
                begin
                    tb_next = crc_val[15:8];
                end
                else if (j_reg == TXW'(0))
                begin
                    tb_next = addr_reg;
                end
                else if (j_reg == TXW'(1))
                begin
                    tb_next = (rk_reg == RK_EXC) ? (EXC_FLAG + fc_reg) : fc_reg;
                end
                else
                begin
                    case (rk_reg)
                        RK_EXC:
                        begin
                            tb_next = code_reg;
                        end
                        RK_READ:
                        begin
                            if (j_reg == TXW'(2))
                            begin
                                tb_next = {qt_reg[6:0], 1'b0};
                            end
                            else if (!rd_off[0])
                            begin
                                // high byte: fetch the next word
                                state_next = S_TX_RD;
                            end
                            else
                            begin
                                tb_next = word_reg[7:0];
                            end
                        end
                        default:
                        begin
                            case (j_reg)
                                TXW'(2): tb_next = st_reg[15:8];
                                TXW'(3): tb_next = st_reg[7:0];
                                TXW'(4): tb_next = qt_reg[15:8];
                                default: tb_next = qt_reg[7:0];
                            endcase
                        end
                    endcase
                end
            end

            S_TX_RD:
            begin
                word_next  = hram_rdata;
                tb_next    = hram_rdata[15:8];
                wa_next    = wa_reg + AW'(1);
                state_next = S_TX_LD;
            end

            S_TX_LD:
            begin
                if (j_reg < body_n)
                begin
                    crc_ctl.init = (j_reg == '0);
                    crc_ctl.load = 1'b1;
                    crc_ctl.data = tb_reg;
                end
                state_next = S_TX_OUT;
            end

            S_TX_OUT:
            begin
                if (!crc_busy && !out_valid_reg)
                begin
                    out_load = 1'b1;
                    o_byte   = tb_reg;
                    o_last   = (j_reg == body_n + TXW'(1));
                    if (j_reg == body_n + TXW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + TXW'(1);
                        state_next = S_TX_SEL;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            len_reg       <= '0;
            clr_reg       <= '0;
            addr_reg      <= ADDR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            clr_reg   <= clr_next;
            if (cfg_valid && cfg_ready)
            begin
                addr_reg <= slave_address;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fc_reg    <= fc_next;
        st_reg    <= st_next;
        qt_reg    <= qt_next;
        bc_reg    <= bc_next;
        code_reg  <= code_next;
        rk_reg    <= rk_next;
        j_reg     <= j_next;
        tb_reg    <= tb_next;
        word_reg  <= word_next;
        wa_reg    <= wa_next;
        fp_reg    <= fp_next;
        wc_reg    <= wc_next;
        hb_reg    <= hb_next;
        lr_ok_reg <= lr_ok_next;
        if (out_load)
        begin
            kind_reg       <= o_kind;
            tx_byte_reg    <= o_byte;
            tx_last_reg    <= o_last;
            read_value_reg <= o_val;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign tx_byte    = tx_byte_reg;
    assign tx_last    = tx_last_reg;
    assign read_value = read_value_reg;

    // frame length never runs past the buffer
    `MRTU_ASSERT_IMPL(a_len_bound, 1'b1, len_reg <= FB)
    // the CRC unit only runs while the sequencer waits on it
    `MRTU_ASSERT_IMPL(a_crc_owner, crc_busy, state_reg == S_RX_CRC || state_reg == S_TX_OUT)
    // a beat is never loaded over an unfinished CRC
    `MRTU_ASSERT_IMPL(a_load_crc, out_load && !o_kind, !crc_busy)
    // a finished decision either goes idle or has closed the frame
    `MRTU_ASSERT_NEXT(a_frame_close, state_reg == S_RX_CRC && !crc_busy,
                      state_reg == S_IDLE || len_reg == '0)

endmodule

`default_nettype wire

// ===== tb/modbus_frame_checker.sv =====
`default_nettype none

module modbus_frame_checker
    import mrtu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [9:0]  local_index,
    input  wire logic [15:0] local_value,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        kind,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        tx_last,
    input  wire logic [15:0] read_value,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  slave_address,
    output int               fail_count,
    output int               pending,
    output int               frames_seen,
    output int               lreads_seen
);

    localparam int MEM_WORDS    = 1024;
    localparam int MAX_QUANTITY = 29;
    localparam int FRAME_BYTES  = 256;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] read_value;
    } beat_t;

    beat_t       expected_beats[$];
    logic [7:0]  rx_frame[FRAME_BYTES];
    int          rx_len;
    logic [15:0] regs[MEM_WORDS];
    logic [7:0]  station;

    assign pending = expected_beats.size();

    function automatic logic [15:0] crc_of(logic [7:0] bytes[$]);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (bytes[k])
        begin
            c ^= {8'h00, bytes[k]};
            for (int b = 0; b < 8; b++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic queue_response(logic [7:0] bytes[$]);
        logic [15:0] c;
        beat_t       bt;
        c = crc_of(bytes);
        bytes.push_back(c[7:0]);
        bytes.push_back(c[15:8]);
        foreach (bytes[k])
        begin
            bt = '{kind: 1'b0, tx_byte: bytes[k], tx_last: (k == bytes.size() - 1),
                   read_value: 16'h0};
            expected_beats.push_back(bt);
        end
        frames_seen++;
    endtask

    // Complete frame of n bytes: validate, execute, build response.
    task automatic serve_request(int n);
        logic [7:0]  fc;
        int          start;
        int          qty;
        int          code;
        logic [7:0]  rsp[$];
        logic [7:0]  body[$];
        logic [15:0] got_crc;
        fc = rx_frame[1];
        start = {rx_frame[2], rx_frame[3]};
        qty = {rx_frame[4], rx_frame[5]};
        code = -1;
        rx_len = 0;
        for (int k = 0; k < n - 2; k++)
            body.push_back(rx_frame[k]);
        got_crc = {rx_frame[n-1], rx_frame[n-2]};
        if (crc_of(body) != got_crc)
            code = EXC_BAD_CRC;
        if (qty == 0 || qty > MAX_QUANTITY || start + qty > MEM_WORDS)
            code = EXC_BAD_REQ;
        if (fc == FC_WRITE && rx_frame[6] != 2 * qty)
            code = EXC_BAD_REQ;
        rsp.push_back(station);
        if (code >= 0)
        begin
            rsp.push_back(EXC_FLAG + fc);
            rsp.push_back(8'(code));
        end
        else if (fc == FC_READ)
        begin
            rsp.push_back(fc);
            rsp.push_back(8'(2 * qty));
            for (int k = 0; k < qty; k++)
            begin
                rsp.push_back(regs[start + k][15:8]);
                rsp.push_back(regs[start + k][7:0]);
            end
        end
        else
        begin
            rsp.push_back(fc);
            for (int k = 0; k < qty; k++)
                regs[start + k] = {rx_frame[7 + 2*k], rx_frame[8 + 2*k]};
            for (int k = 2; k < 6; k++)
                rsp.push_back(rx_frame[k]);
        end
        queue_response(rsp);
    endtask

    task automatic take_item(logic [1:0] m, logic [7:0] b, logic [9:0] idx, logic [15:0] v);
        beat_t bt;
        int    need;
        case (m)
            MODE_LWRITE:
                regs[idx] = v;
            MODE_LREAD:
            begin
                bt = '{kind: 1'b1, tx_byte: 8'h0, tx_last: 1'b0, read_value: regs[idx]};
                expected_beats.push_back(bt);
                lreads_seen++;
            end
            MODE_SERIAL:
            begin
                if (rx_len == 0 && b != station)
                    return;
                rx_frame[rx_len] = b;
                rx_len++;
                if (rx_len < 2)
                    return;
                if (rx_frame[1] == FC_READ)
                begin
                    if (rx_len == 8)
                        serve_request(8);
                end
                else if (rx_frame[1] == FC_WRITE)
                begin
                    if (rx_len >= 7)
                    begin
                        need = 9 + rx_frame[6];
                        if (need > FRAME_BYTES)
                            rx_len = 0;
                        else if (rx_len == need)
                            serve_request(need);
                    end
                end
                else
                    rx_len = 0;
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, beat_t got, beat_t want);
        $display("mismatch %s: got k=%0d b=%02h l=%0d v=%04h want k=%0d b=%02h l=%0d v=%04h",
                 what, got.kind, got.tx_byte, got.tx_last, got.read_value,
                 want.kind, want.tx_byte, want.tx_last, want.read_value);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t got;
        beat_t want;
        if (!rst_n)
        begin
            expected_beats.delete();
            rx_len = 0;
            station = ADDR_RESET;
            fail_count = 0;
            frames_seen = 0;
            lreads_seen = 0;
            foreach (regs[k])
                regs[k] = 16'h0;
        end
        else
        begin
            // output first: a response beat cannot come from this edge's input beat
            if (out_valid && !out_stall)
            begin
                got = '{kind: kind, tx_byte: tx_byte, tx_last: tx_last, read_value: read_value};
                if (expected_beats.size() == 0)
                    report("unexpected beat", got, got);
                else
                begin
                    want = expected_beats.pop_front();
                    if (got !== want)
                        report("field", got, want);
                end
            end
            if (cfg_valid && cfg_ready)
                station = slave_address;
            if (in_valid && !in_stall)
                take_item(mode, rx_byte, local_index, local_value);
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
    import mrtu_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [7:0]  rx_byte;
    logic [9:0]  local_index;
    logic [15:0] local_value;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] read_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  slave_address;

    int fail_count;
    int pending;
    int frames_seen;
    int lreads_seen;
    int items_sent;
    int idle_cycles;

    // receiver and sender behavior, set by the stimulus thread
    bit stall_bursts;
    bit hold_off_req;
    bit send_bursts;

    logic [7:0] station;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    modbus_rtu_slave_engine_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .rx_byte(rx_byte),
        .local_index(local_index), .local_value(local_value),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .tx_byte(tx_byte),
        .tx_last(tx_last), .read_value(read_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .slave_address(slave_address)
    );

    modbus_frame_checker i_checker (.*);

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (1500) @(posedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (stall_bursts && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: cycles with no beat on either channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else if (++idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // One input beat; sender gap bursts taken before it.
    task automatic send_item(logic [1:0] m, logic [7:0] b, logic [9:0] idx, logic [15:0] v);
        if (send_bursts && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        rx_byte <= b;
        local_index <= idx;
        local_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_bytes(logic [7:0] bytes[$]);
        foreach (bytes[k])
            send_item(MODE_SERIAL, bytes[k], 10'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] frame_crc(logic [7:0] bytes[$]);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (bytes[k])
        begin
            c ^= {8'h00, bytes[k]};
            for (int b = 0; b < 8; b++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Builds and sends a request; bad_crc flips one bit of the check bytes.
    task automatic send_request(logic [7:0] fc, int start, int qty, int bcount, bit bad_crc);
        logic [7:0]  f[$];
        logic [15:0] c;
        f = {station, fc, 8'(start >> 8), 8'(start), 8'(qty >> 8), 8'(qty)};
        if (fc == FC_WRITE)
        begin
            f.push_back(8'(bcount));
            for (int k = 0; k < bcount; k++)
                f.push_back(8'($urandom));
        end
        c = frame_crc(f);
        if (bad_crc)
            c ^= 16'(1 << $urandom_range(0, 15));
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        send_bytes(f);
    endtask

    task automatic random_request();
        int  r;
        int  qty;
        int  start;
        bit  wr;
        r = $urandom_range(0, 99);
        wr = $urandom_range(0, 1);
        qty = $urandom_range(1, 6);
        start = (r < 8) ? $urandom_range(0, 65535) : $urandom_range(0, 1023 - qty);
        if (r < 8)
            send_request(wr ? FC_WRITE : FC_READ, start, qty, 2 * qty, 0);
        else if (r < 14)
            send_request(wr ? FC_WRITE : FC_READ, start, $urandom_range(0, 65535),
                         2 * qty, 0);
        else if (r < 20)
            send_request(wr ? FC_WRITE : FC_READ, start, qty, 2 * qty, 1);
        else if (r < 24)
            send_request(FC_WRITE, start, qty, $urandom_range(0, 20), $urandom_range(0, 1));
        else
            send_request(wr ? FC_WRITE : FC_READ, start, qty, 2 * qty, 0);
    endtask

    task automatic local_traffic();
        int n;
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
            send_item(2'($urandom_range(0, 3)), 8'($urandom), 10'($urandom),
                      16'($urandom));
    endtask

    // let the checker take the last input beat first, then wait until nothing is pending
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_station(logic [7:0] a);
        cfg_valid <= 1'b1;
        slave_address <= a;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        station = a;
    endtask

    initial
    begin
        logic [7:0] stations[4];
        stations = '{8'd1, 8'd247, 8'd17, 8'd128};
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_SERIAL;
        rx_byte = 8'h0;
        local_index = 10'h0;
        local_value = 16'h0;
        cfg_valid = 1'b0;
        slave_address = ADDR_RESET;
        station = ADDR_RESET;
        stall_bursts = 1'b0;
        send_bursts = 1'b0;
        hold_off_req = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset address, extremes of local fields, each special case.
        send_item(MODE_LWRITE, 8'h00, 10'd1023, 16'hFFFF);
        send_item(MODE_LWRITE, 8'hFF, 10'd0, 16'h0000);
        send_item(MODE_LREAD, 8'h00, 10'd1023, 16'h0);
        send_item(MODE_LREAD, 8'h00, 10'd0, 16'hFFFF);
        send_item(MODE_NONE, 8'hFF, 10'd1023, 16'hFFFF);
        send_item(MODE_SERIAL, 8'hFF, 10'd0, 16'h0);          // foreign start
        send_bytes({station, 8'h07});                           // unknown function
        send_bytes({station, FC_WRITE, 8'h0, 8'h0, 8'h0, 8'h1, 8'hFF}); // oversized
        send_request(FC_READ, 1022, 2, 4, 0);
        send_request(FC_READ, 0, 0, 0, 1);                      // bad request and CRC
        send_request(FC_READ, 0, 30, 60, 0);
        send_request(FC_WRITE, 0, 29, 58, 0);                   // longest write
        send_request(FC_READ, 0, 29, 58, 0);                    // longest response
        send_request(FC_WRITE, 4, 2, 3, 0);                     // byte count mismatch
        drain();

        foreach (stations[p])
        begin
            write_station(stations[p]);
            stall_bursts = (p != 3);
            send_bursts = (p != 3);
            if (p == 1)
            begin
                hold_off_req = 1'b1;
                // keep offering reads while the receiver holds off
                repeat (60)
                    send_item(MODE_LREAD, 8'h0, 10'($urandom), 16'h0);
            end
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(MODE_SERIAL, 8'($urandom), 10'h0, 16'h0);
                random_request();
                local_traffic();
            end
            drain();
        end

        $display("items sent %0d, response frames %0d, local reads %0d",
                 items_sent, frames_seen, lreads_seen);
        $display("four station addresses, directed corner frames, then random traffic");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/mrtu_pkg.sv
rtl/mrtu_ram.sv
rtl/mrtu_crc.sv
rtl/modbus_rtu_slave_engine_unit.sv
tb/modbus_frame_checker.sv
tb/tb_top.sv
